@@ rtl/olist_pkg.sv @@
// ----------------------------------------------------------------------------
// olist_pkg
// Shared constants, codes and controller/datapath interface types for the
// ordered list block.
// ----------------------------------------------------------------------------
package olist_pkg;

    localparam int OL_CAPACITY = 16;

    localparam int CMD_W     = 2;
    localparam int VAL_W     = 32;
    localparam int STS_W     = 2;
    localparam int CNT_OUT_W = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TRAVERSE = 2'd2;

    // status codes
    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL      = 2'd1;
    localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd2;
    localparam logic [STS_W-1:0] STS_EMPTY     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_TRAV,
        S_EXEC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch;       // take the input word, clear index and match flag
        logic idx_inc;
        logic found_set;
        logic shift_wr;    // mem[idx-1] <= mem[idx]
        logic cnt_dec;
        logic load_item;   // output word carries a stored entry
        logic load_reply;  // output word carries the single reply
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;
        logic idx_end;     // index reached the entry count
        logic match;       // entry at index equals the search value
        logic last_item;   // index is the tail entry
        logic can_load;    // output register free or being drained
    } t_dp_sts;

endpackage

@@ rtl/olist_datapath.sv @@
// ----------------------------------------------------------------------------
// olist_datapath
// Entry memory, count and index registers, compare logic and the output
// register of the ordered list.
// ----------------------------------------------------------------------------
module olist_datapath #(
    parameter int CAPACITY = olist_pkg::OL_CAPACITY
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [olist_pkg::CMD_W-1:0]             i_in_cmd,
    input  logic [olist_pkg::VAL_W-1:0]             i_in_value,
    input  logic                                    i_m_tready,
    output logic                                    o_m_tvalid,
    output logic [olist_pkg::STS_W-1:0]             o_status,
    output logic [olist_pkg::VAL_W-1:0]             o_out_value,
    output logic                                    o_last,
    output logic [olist_pkg::CNT_OUT_W-1:0]         o_entry_count,
    input  olist_pkg::t_dp_cmd                      i_cmd,
    output olist_pkg::t_dp_sts                      o_sts
);
    import olist_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rd_data;

    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CMD_W-1:0] r_cmd;
    logic [VAL_W-1:0] r_val;
    logic             r_found;

    logic             r_out_valid;
    logic [STS_W-1:0] r_out_status;
    logic [VAL_W-1:0] r_out_value;
    logic             r_out_last;
    logic [CW-1:0]    r_out_count;

    logic             full;
    logic             app_wr;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic             wr_en;
    logic [STS_W-1:0] reply_status;
    logic [CW+CNT_OUT_W-1:0] count_ext;

    assign full   = (r_count == CW'(CAPACITY));
    assign app_wr = i_cmd.load_reply && (r_cmd == CMD_APPEND) && !full;

    always_comb begin
        if (i_cmd.latch) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + CW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    always_comb begin
        if (app_wr) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    // read where the index moves to; r_rd_data tracks mem[r_idx] below CAPACITY
    assign rd_addr = (n_idx < CW'(CAPACITY)) ? n_idx[AW-1:0] : '0;

    always_comb begin
        wr_en   = i_cmd.shift_wr || app_wr;
        wr_addr = i_cmd.shift_wr ? AW'(r_idx - CW'(1)) : r_count[AW-1:0];
        wr_data = i_cmd.shift_wr ? r_rd_data : r_val;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        case (r_cmd)
            CMD_APPEND:   reply_status = full ? STS_FULL : STS_OK;
            CMD_DELETE:   reply_status = r_found ? STS_OK : STS_NOT_FOUND;
            CMD_TRAVERSE: reply_status = STS_EMPTY;
            default:      reply_status = STS_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
            if (i_cmd.latch) begin
                r_found <= 1'b0;
            end else if (i_cmd.found_set) begin
                r_found <= 1'b1;
            end
            if (i_cmd.load_item || i_cmd.load_reply) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd <= i_in_cmd;
            r_val <= i_in_value;
        end
        if (i_cmd.load_item) begin
            r_out_status <= STS_OK;
            r_out_value  <= r_rd_data;
            r_out_last   <= o_sts.last_item;
            r_out_count  <= r_count;
        end else if (i_cmd.load_reply) begin
            r_out_status <= reply_status;
            r_out_value  <= '0;
            r_out_last   <= 1'b1;
            r_out_count  <= n_count;
        end
    end

    always_comb begin
        o_sts.count_zero = (r_count == '0);
        o_sts.idx_end    = (r_idx >= r_count);
        o_sts.match      = (r_rd_data == r_val);
        o_sts.last_item  = ((r_idx + CW'(1)) == r_count);
        o_sts.can_load   = !r_out_valid || i_m_tready;
    end

    assign count_ext     = {{CNT_OUT_W{1'b0}}, r_out_count};
    assign o_m_tvalid    = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_value   = r_out_value;
    assign o_last        = r_out_last;
    assign o_entry_count = count_ext[CNT_OUT_W-1:0];

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_dec_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |-> (r_count != '0) && r_found)
        else $error("count decrement without a removed entry");

    a_append_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        app_wr |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not grow the list");

    a_one_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.shift_wr && i_cmd.load_reply))
        else $error("two writes to the entry memory in one cycle");

endmodule

@@ rtl/olist_ctrl.sv @@
// ----------------------------------------------------------------------------
// olist_ctrl
// Controller state machine: dispatches commands and steps the datapath
// through search, compaction, traversal and reply.
// ----------------------------------------------------------------------------
module olist_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [olist_pkg::CMD_W-1:0] i_in_cmd,
    output logic                        o_ready,
    input  olist_pkg::t_dp_sts          i_sts,
    output olist_pkg::t_dp_cmd          o_cmd
);
    import olist_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_in_cmd == CMD_DELETE) begin
                        n_state = S_SEARCH;
                    end else if (i_in_cmd == CMD_TRAVERSE && !i_sts.count_zero) begin
                        n_state = S_TRAV;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_SEARCH: begin
                if (i_sts.idx_end) begin
                    n_state = S_EXEC;
                end else if (i_sts.match) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_sts.idx_end) begin
                    n_state = S_EXEC;
                end
            end
            S_TRAV: begin
                if (i_sts.can_load && i_sts.last_item) begin
                    n_state = S_IDLE;
                end
            end
            S_EXEC: begin
                if (i_sts.can_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.latch = i_valid;
            end
            S_SEARCH: begin
                o_cmd.idx_inc   = !i_sts.idx_end;
                o_cmd.found_set = !i_sts.idx_end && i_sts.match;
            end
            S_SHIFT: begin
                o_cmd.cnt_dec  = i_sts.idx_end;
                o_cmd.shift_wr = !i_sts.idx_end;
                o_cmd.idx_inc  = !i_sts.idx_end;
            end
            S_TRAV: begin
                o_cmd.load_item = i_sts.can_load;
                o_cmd.idx_inc   = i_sts.can_load;
            end
            S_EXEC: begin
                o_cmd.load_reply = i_sts.can_load;
            end
            default: ;
        endcase
    end

    a_trav_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRAV && o_cmd.load_item && i_sts.last_item) |=> (r_state == S_IDLE))
        else $error("traversal did not stop at the tail");

    a_trav_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRAV) |-> !i_sts.idx_end)
        else $error("traversal index ran past the tail");

    a_shift_after_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_SHIFT) |-> $past(o_cmd.found_set))
        else $error("compaction without a matching entry");

endmodule

@@ rtl/ordered_list_delete_by_value.sv @@
// ----------------------------------------------------------------------------
// ordered_list_delete_by_value
// Bounded insertion-ordered list of signed 32-bit values with append,
// delete-first-match and traverse commands.
// ----------------------------------------------------------------------------
// One command is worked at a time; the input is ready only between commands.
// Append and the unused code go straight to the reply load. Delete walks the
// stored entries one per cycle through the entry memory (one read and one
// write port), first searching up to the match, then moving each later entry
// one place toward the head, before its reply load. Traverse loads one word
// per cycle while the output side takes them, or a reply with empty status for
// an empty list. The memory walk sets the throughput. The output word
// sits in a register, so a new command is taken while the last word of the
// previous one still waits; a stall on the output side holds the traversal
// and the reply load, while the delete search and compaction run on.
// ----------------------------------------------------------------------------
module ordered_list_delete_by_value #(
    parameter int CAPACITY = olist_pkg::OL_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] item_value
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] out_value, [36:32] entry_count, rest zero
    output logic [1:0]  o_m_tuser,   // [1:0] status
    output logic        o_m_tlast    // last_of_run
);
    import olist_pkg::*;

    t_dp_cmd              dp_cmd;
    t_dp_sts              dp_sts;
    logic [VAL_W-1:0]     out_value;
    logic [CNT_OUT_W-1:0] entry_count;

    olist_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_in_cmd (i_s_tuser),
        .o_ready  (o_s_tready),
        .i_sts    (dp_sts),
        .o_cmd    (dp_cmd)
    );

    olist_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_cmd      (i_s_tuser),
        .i_in_value    (i_s_tdata),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_status      (o_m_tuser),
        .o_out_value   (out_value),
        .o_last        (o_m_tlast),
        .o_entry_count (entry_count),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts)
    );

    assign o_m_tdata = {3'b000, entry_count, out_value};

endmodule
